>>> rtl/itoa_pkg.sv
package itoa_pkg;

  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 8;

  localparam logic [6:0] ASCII_ZERO    = 7'd48;
  localparam logic [6:0] ASCII_LOWER_A = 7'd97;
  localparam logic [6:0] ASCII_UPPER_A = 7'd65;
  localparam logic [6:0] ASCII_MINUS   = 7'd45;
  localparam logic [3:0] DEC_RADIX     = 4'd10;
  localparam logic [3:0] MAX_DEC_DIGIT = 4'd9;
  localparam logic [4:0] MIN_RADIX     = 5'd2;
  localparam logic [4:0] MAX_RADIX     = 5'd16;

  typedef struct packed {
    logic [4:0] radix;
    logic       upper;
    logic       neg;
  } job_ctrl_t;

  function automatic logic [6:0] char_of_digit(input logic [3:0] d, input logic upper);
    logic [6:0] base_char;
    base_char = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
    if (d <= MAX_DEC_DIGIT) begin
      return ASCII_ZERO + {3'b000, d};
    end
    return base_char + {3'b000, d - DEC_RADIX};
  endfunction

endpackage

>>> rtl/itoa_ram.sv
module itoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/itoa_front.sv
module itoa_front #(
  parameter int VALUE_BITS = 64
) (
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [itoa_pkg::S_TDATA_W-1:0] s_tdata,  // value[63:0], base[68:64], upper_case[69]
  input  logic                        s_tuser,   // func
  output logic                        q_valid,
  input  logic                        q_ready,
  output logic [VALUE_BITS-1:0]       q_value,
  output itoa_pkg::job_ctrl_t         q_ctrl
);

  import itoa_pkg::*;

  logic [63:0] masked;
  logic [31:0] low;
  logic [31:0] mag;
  logic [4:0]  base;

  always_comb begin
    masked = 64'(s_tdata[VALUE_BITS-1:0]);
    low    = masked[31:0];
    mag    = low[31] ? (~low + 32'd1) : low;
    base   = s_tdata[68:64];
    q_ctrl.upper = s_tdata[69];
    if (s_tuser) begin
      q_ctrl.neg   = low[31];
      q_ctrl.radix = {1'b0, DEC_RADIX};
      q_value      = VALUE_BITS'({32'd0, mag});
    end else begin
      q_ctrl.neg = 1'b0;
      q_value    = masked[VALUE_BITS-1:0];
      if (base inside {[MIN_RADIX:MAX_RADIX]}) begin
        q_ctrl.radix = base;
      end else if (base < MIN_RADIX) begin
        q_ctrl.radix = MIN_RADIX;
      end else begin
        q_ctrl.radix = MAX_RADIX;
      end
    end
  end

  assign q_valid  = s_tvalid;
  assign s_tready = q_ready;

endmodule

>>> rtl/itoa_queue.sv
module itoa_queue #(
  parameter int WIDTH = 71
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

>>> rtl/itoa_back.sv
module itoa_back #(
  parameter int VALUE_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  logic [VALUE_BITS-1:0]          q_value,
  input  itoa_pkg::job_ctrl_t            q_ctrl,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [itoa_pkg::M_TDATA_W-1:0] m_tdata,  // digit_char[6:0], zero[7]
  output logic                           m_tlast   // last
);

  import itoa_pkg::*;

  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int BW = $clog2(VALUE_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_MINUS = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]            state, state_next;
  logic [VALUE_BITS-1:0] num, num_next;
  logic [3:0]            rem, rem_next;
  logic [BW-1:0]         bitcnt, bitcnt_next;
  logic [CW-1:0]         ndig, ndig_next;
  job_ctrl_t             ctrl, ctrl_next;
  logic                  ovalid_next;
  logic [6:0]            ochar, ochar_next;
  logic                  olast_next;

  logic       out_free;
  logic [4:0] trial;
  logic       ge;
  logic       we;
  logic       re;
  logic [3:0] rdata;

  itoa_ram #(.WIDTH(4), .DEPTH(VALUE_BITS)) u_digits (
    .clk   (clk),
    .we    (we),
    .waddr (ndig[AW-1:0]),
    .wdata (rem),
    .re    (re),
    .raddr (AW'(ndig - CW'(1))),
    .rdata (rdata)
  );

  assign m_tdata = {1'b0, ochar};

  always_comb begin
    state_next  = state;
    num_next    = num;
    rem_next    = rem;
    bitcnt_next = bitcnt;
    ndig_next   = ndig;
    ctrl_next   = ctrl;
    ovalid_next = m_tvalid && !m_tready;
    ochar_next  = ochar;
    olast_next  = m_tlast;
    q_ready     = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    out_free    = !m_tvalid || m_tready;
    trial       = {rem, num[VALUE_BITS-1]};
    ge          = (trial >= ctrl.radix);
    case (state)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          num_next    = q_value;
          ctrl_next   = q_ctrl;
          rem_next    = 4'd0;
          bitcnt_next = '0;
          ndig_next   = '0;
          state_next  = S_DIV;
        end
      end
      S_DIV: begin
        rem_next    = ge ? 4'(trial - ctrl.radix) : trial[3:0];
        num_next    = {num[VALUE_BITS-2:0], ge};
        bitcnt_next = bitcnt + BW'(1);
        if (bitcnt == BW'(VALUE_BITS - 1)) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        we          = 1'b1;
        ndig_next   = ndig + CW'(1);
        rem_next    = 4'd0;
        bitcnt_next = '0;
        if (num == '0) begin
          state_next = ctrl.neg ? S_MINUS : S_READ;
        end else begin
          state_next = S_DIV;
        end
      end
      S_MINUS: begin
        if (out_free) begin
          ovalid_next = 1'b1;
          ochar_next  = ASCII_MINUS;
          olast_next  = 1'b0;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        re         = 1'b1;
        ndig_next  = ndig - CW'(1);
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_next = 1'b1;
          ochar_next  = char_of_digit(rdata, ctrl.upper);
          olast_next  = (ndig == '0);
          state_next  = (ndig == '0) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    num     <= num_next;
    rem     <= rem_next;
    bitcnt  <= bitcnt_next;
    ndig    <= ndig_next;
    ctrl    <= ctrl_next;
    ochar   <= ochar_next;
    m_tlast <= olast_next;
  end

endmodule

>>> rtl/integer_to_ascii_digits_unit.sv
// Converts one number per input beat into ASCII digits, most significant first, one
// character per output beat with tlast on the final one. Unsigned mode writes the
// VALUE_BITS-wide value in radix 2..16 (base clamped into that range); signed mode
// writes the low 32 bits as a two's complement decimal number, with a leading minus
// when negative. Each digit comes from a bit-serial divider that shifts through every
// value bit and then stores the remainder; every character is then read back from
// the digit store and sent. A two-beat queue sits between input classification
// and the divider, so input beats are taken while the previous number is still
// converting.
module integer_to_ascii_digits_unit #(
  parameter int VALUE_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [itoa_pkg::S_TDATA_W-1:0] s_tdata,  // value[63:0], base[68:64], upper_case[69]
  input  logic                           s_tuser,  // func
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [itoa_pkg::M_TDATA_W-1:0] m_tdata,  // digit_char[6:0], zero[7]
  output logic                           m_tlast   // last
);

  import itoa_pkg::*;

  localparam int JW = VALUE_BITS + $bits(job_ctrl_t);

  logic                  f_valid;
  logic                  f_ready;
  logic [VALUE_BITS-1:0] f_value;
  job_ctrl_t             f_ctrl;
  logic                  b_valid;
  logic                  b_ready;
  logic [JW-1:0]         b_job;
  job_ctrl_t             b_ctrl;

  itoa_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_value  (f_value),
    .q_ctrl   (f_ctrl)
  );

  itoa_queue #(.WIDTH(JW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_ctrl, f_value}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_job)
  );

  assign b_ctrl = b_job[JW-1:VALUE_BITS];

  itoa_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_value  (b_job[VALUE_BITS-1:0]),
    .q_ctrl   (b_ctrl),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> rtl/itoa_checker.sv
module itoa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [itoa_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tlast
);

  import itoa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7] == 1'b0)
    else $error("pad bit of output set");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6:0] == ASCII_MINUS |-> !m_tlast)
    else $error("minus sign ended a run");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind integer_to_ascii_digits_unit itoa_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
